### hdl/lpht_pkg.sv
// shared types and constants for the linear probing hash table
package lpht_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VAL_W       = 64;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned LOG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

  localparam logic [LOG_W-1:0] LOG_SIZE_RESET  = 4'd10;
  localparam logic [LOG_W-1:0] LOG_SIZE_MIN    = 4'd3;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 11'd768;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 11'd2047;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] old_value;
    logic             hit;
    logic             table_full;
    logic             resize_needed;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic probe_done;
  } dp_sts_t;

endpackage

### hdl/lpht_ctrl.sv
// controller state machine: clearing pass, probe loop, finish
module lpht_ctrl import lpht_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK} state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.probe_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### hdl/lpht_dp.sv
// datapath: slot memories, probe position, count and result register
module lpht_dp import lpht_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  req_t                  req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output rsp_t                  rsp_o,
  output logic                  rsp_valid_o
);

  // key and tombstone share a word, value sits apart
  logic [KEY_W:0]   kmem [TABLE_DEPTH];
  logic [VAL_W-1:0] vmem [TABLE_DEPTH];

  logic [LOG_W-1:0]  log_q;
  logic [CNT_W-1:0]  thr_q;
  logic [CNT_W-1:0]  occ_q, occ_d;
  req_t              req_q;
  logic [ADDR_W-1:0] pos_q, cnt_q, clr_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic              rd_tomb_q;
  logic [VAL_W-1:0]  rd_val_q;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q;

  logic [LOG_W-1:0]  log_eff;
  logic [ADDR_W-1:0] mask;
  logic              bad, match, empty, last, live, is_ins;
  logic              kw, vw, tomb_new;
  logic [KEY_W:0]    kw_data;
  logic [ADDR_W-1:0] waddr;

  // size mask from configured log size
  assign log_eff = (log_q < LOG_SIZE_MIN) ? LOG_SIZE_MIN : log_q;
  always_comb begin
    for (int b = 0; b < ADDR_W; b++) begin
      mask[b] = (LOG_W'(b) < log_eff);
    end
  end

  // probe outcome
  assign bad    = (req_q.key == '0) || (req_q.cmd > CMD_REMOVE);
  assign empty  = (rd_key_q == '0);
  assign match  = (rd_key_q == req_q.key);
  assign last   = (cnt_q == mask);
  assign live   = !rd_tomb_q;
  assign is_ins = (req_q.cmd == CMD_PUT) || (req_q.cmd == CMD_ADD);

  assign sts_o.probe_done = bad || empty || match || last;
  assign sts_o.clr_last   = (clr_q == ADDR_W'(TABLE_DEPTH - 1));

  // command effects at the end of a probe
  always_comb begin
    rsp_d    = '0;
    kw       = 1'b0;
    vw       = 1'b0;
    tomb_new = rd_tomb_q;
    occ_d    = occ_q;
    if (!bad) begin
      if (match) begin
        case (req_q.cmd)
          CMD_GET: begin
            if (live) begin
              rsp_d.old_value = rd_val_q;
              rsp_d.hit       = 1'b1;
            end
          end
          CMD_PUT: begin
            if (live) begin
              rsp_d.old_value = rd_val_q;
              rsp_d.hit       = 1'b1;
            end
            vw       = 1'b1;
            kw       = 1'b1;
            tomb_new = 1'b0;
          end
          CMD_REPLACE: begin
            if (live) begin
              rsp_d.old_value = rd_val_q;
              rsp_d.hit       = 1'b1;
              vw              = 1'b1;
            end
          end
          CMD_ADD: begin
            if (!live) begin
              vw        = 1'b1;
              kw        = 1'b1;
              tomb_new  = 1'b0;
              rsp_d.hit = 1'b1;
            end
          end
          default: begin
            if (live) begin
              rsp_d.old_value = rd_val_q;
              rsp_d.hit       = 1'b1;
              kw              = 1'b1;
              tomb_new        = 1'b1;
            end
          end
        endcase
      end else if (is_ins) begin
        if (empty) begin
          kw                  = 1'b1;
          vw                  = 1'b1;
          tomb_new            = 1'b0;
          rsp_d.resize_needed = (occ_q >= thr_q);
          rsp_d.hit           = (req_q.cmd == CMD_ADD);
          if (occ_q < COUNT_MAX) occ_d = occ_q + 1'b1;
        end else begin
          rsp_d.table_full = 1'b1;
        end
      end
    end
  end

  assign waddr   = cmd_i.clr_wr ? clr_q : pos_q;
  assign kw_data = cmd_i.clr_wr ? '0 : {req_q.key, tomb_new};

  // slot memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || (cmd_i.finish && kw)) kmem[waddr] <= kw_data;
    if (cmd_i.finish && vw) vmem[pos_q] <= req_q.new_value;
    if (cmd_i.rd) begin
      {rd_key_q, rd_tomb_q} <= kmem[pos_q];
      rd_val_q              <= vmem[pos_q];
    end
  end

  // request and probe registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      pos_q <= req_i.key[ADDR_W-1:0] & mask;
    end else if (cmd_i.step) begin
      pos_q <= (pos_q + 1'b1) & mask;
    end
    if (cmd_i.finish) rsp_q <= rsp_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_q       <= LOG_SIZE_RESET;
      thr_q       <= THRESHOLD_RESET;
      occ_q       <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_LOG_SIZE)) log_q <= cfg_data_i[LOG_W-1:0];
      if (cfg_we_i && (cfg_index_i == CFG_THRESHOLD)) thr_q <= cfg_data_i;
      if (cmd_i.finish) occ_q <= occ_d;
      if (cmd_i.load) cnt_q <= '0;
      else if (cmd_i.step) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      rsp_valid_q <= cmd_i.finish;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

### hdl/linear_probe_hash_table.sv
// top level of the linear probing hash table
// After reset the block sweeps all 1024 slots to empty, one per cycle (busy high,
// configuration writes still taken). A request is taken when start is high and
// busy low; it probes slots one after another from key masked to the size in use,
// each slot read through the registered read port of the slot memory and then
// checked. Its result appears on rsp_o together with the result_valid_o strobe in
// the cycle after the last slot check, when the next request may already be taken.
// The result cannot be held off by the receiver.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output rsp_t                  rsp_o,
  output logic                  result_valid_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  // controller
  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd)
  );

  // datapath
  lpht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .rsp_o       (rsp_o),
    .rsp_valid_o (result_valid_o)
  );

  // results are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held");

  // an accepted request makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted without busy");

  // a full table never reports a hit
  a_full_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.table_full) |-> !rsp_o.hit) else $error("full with hit");

  // a result follows the end of a probe while busy
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without request");

endmodule

### test/tb.sv
// self-checking testbench for the linear probing hash table
module tb;
  import lpht_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
  localparam int SETTLE_CYCLES = 8;

  // table model with queue of predicted responses
  class table_scoreboard;
    bit [KEY_W-1:0] slot_key [TABLE_DEPTH];
    bit [VAL_W-1:0] slot_val [TABLE_DEPTH];
    bit             slot_dead [TABLE_DEPTH];
    int unsigned    fill_count;
    bit [LOG_W-1:0] log_size;
    bit [CNT_W-1:0] threshold;
    rsp_t           pending [$];
    int             errors;
    int             checked;
    int             hits;
    int             fulls;
    int             resizes;

    function void init();
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
        slot_dead[i] = 1'b0;
      end
      fill_count = 0;
      log_size = LOG_SIZE_RESET;
      threshold = THRESHOLD_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_LOG_SIZE) log_size = data[LOG_W-1:0];
      else if (idx == CFG_THRESHOLD) threshold = data;
    endfunction

    // work out the response of one accepted request and update the table
    function void note_request(req_t r);
      rsp_t        o;
      int unsigned lg, sz, mask, pos;
      bit          found, empty, live;
      o = '0;
      lg = (log_size < LOG_SIZE_MIN) ? LOG_SIZE_MIN : log_size;
      sz = 1 << lg;
      if (sz > TABLE_DEPTH) sz = TABLE_DEPTH;
      mask = sz - 1;
      pos = r.key[31:0] & mask;
      found = 0;
      empty = 0;
      if (r.key != '0 && r.cmd <= CMD_REMOVE) begin
        for (int i = 0; i < sz; i++) begin
          if (slot_key[pos] == '0) begin
            empty = 1;
            break;
          end
          if (slot_key[pos] == r.key) begin
            found = 1;
            break;
          end
          pos = (pos + 1) & mask;
        end
        if (found) begin
          live = !slot_dead[pos];
          case (r.cmd)
            CMD_GET: begin
              if (live) begin
                o.old_value = slot_val[pos];
                o.hit = 1;
              end
            end
            CMD_PUT: begin
              if (live) begin
                o.old_value = slot_val[pos];
                o.hit = 1;
              end
              slot_val[pos] = r.new_value;
              slot_dead[pos] = 0;
            end
            CMD_REPLACE: begin
              if (live) begin
                o.old_value = slot_val[pos];
                o.hit = 1;
                slot_val[pos] = r.new_value;
              end
            end
            CMD_ADD: begin
              if (!live) begin
                slot_val[pos] = r.new_value;
                slot_dead[pos] = 0;
                o.hit = 1;
              end
            end
            default: begin
              if (live) begin
                o.old_value = slot_val[pos];
                o.hit = 1;
                slot_dead[pos] = 1;
              end
            end
          endcase
        end else if (r.cmd == CMD_PUT || r.cmd == CMD_ADD) begin
          if (empty) begin
            slot_key[pos] = r.key;
            slot_val[pos] = r.new_value;
            slot_dead[pos] = 0;
            if (fill_count >= threshold) o.resize_needed = 1;
            if (fill_count < COUNT_MAX) fill_count++;
            if (r.cmd == CMD_ADD) o.hit = 1;
          end else begin
            o.table_full = 1;
          end
        end
      end
      hits += o.hit;
      fulls += o.table_full;
      resizes += o.resize_needed;
      pending.push_back(o);
    endfunction

    // compare one response against the oldest prediction
    function void check_response(rsp_t act);
      rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (act.old_value !== exp.old_value) begin
        $display("%0t: old_value expected %h actual %h", $time, exp.old_value, act.old_value);
        errors++;
      end
      if (act.hit !== exp.hit) begin
        $display("%0t: hit expected %b actual %b", $time, exp.hit, act.hit);
        errors++;
      end
      if (act.table_full !== exp.table_full) begin
        $display("%0t: table_full expected %b actual %b", $time, exp.table_full,
                 act.table_full);
        errors++;
      end
      if (act.resize_needed !== exp.resize_needed) begin
        $display("%0t: resize_needed expected %b actual %b", $time, exp.resize_needed,
                 act.resize_needed);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  req_i = '0;
  rsp_t                  rsp_o;
  logic                  result_valid_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  table_scoreboard sb;
  int              idle_pct;
  bit [KEY_W-1:0]  key_pool [$];

  linear_probe_hash_table dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .rsp_o, .result_valid_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock
  always #10 clk_i = ~clk_i;

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_response(rsp_o);
  end

  // run limit
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

  // wait until every predicted response has arrived
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // issue one request, then maybe idle the sender
  task automatic send(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                      logic [VAL_W-1:0] val);
    req_t r;
    r.cmd = cmd;
    r.key = key;
    r.new_value = val;
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_request(r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random phase over a key pool of pool_n keys
  task automatic run_phase(int log_sz, int thr, int idle, int count, int pool_n);
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int               pick;
    drain();
    write_cfg(CFG_LOG_SIZE, CFG_DATA_W'(log_sz));
    write_cfg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    idle_pct = idle;
    key_pool.delete();
    for (int i = 0; i < pool_n; i++) begin
      key = rand64();
      // some keys share low bits to build clusters
      if ($urandom_range(2) == 0) key[3:0] = 4'($urandom_range(1, 3));
      if (key == '0) key = 64'h1;
      key_pool.push_back(key);
    end
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        drain();
      end
      pick = $urandom_range(99);
      cmd = CMD_W'($urandom_range(CMD_REMOVE));
      key = key_pool[$urandom_range(pool_n - 1)];
      if (pick < 3) cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      else if (pick < 5) key = '0;
      else if (pick < 10) key = rand64() | 64'h1;
      send(cmd, key, rand64());
    end
  endtask

  initial begin
    logic [KEY_W-1:0] ka, kb;
    sb = new();
    sb.init();
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every command, tombstone paths, zero key, unknown commands
    ka = 64'hFFFF_FFFF_FFFF_FFFF;
    kb = 64'h8000_0000_0000_03FF;
    send(CMD_GET, ka, 64'h0);
    send(CMD_PUT, ka, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_GET, ka, 64'h0);
    send(CMD_PUT, ka, 64'h0);
    send(CMD_REPLACE, ka, 64'h1234_5678_9ABC_DEF0);
    send(CMD_REPLACE, kb, 64'h5);
    send(CMD_ADD, ka, 64'h6);
    send(CMD_ADD, kb, 64'h7);
    send(CMD_REMOVE, ka, 64'h0);
    send(CMD_GET, ka, 64'h0);
    send(CMD_REPLACE, ka, 64'h9);
    send(CMD_REMOVE, ka, 64'h0);
    send(CMD_ADD, ka, 64'hA);
    send(CMD_REMOVE, ka, 64'h0);
    send(CMD_PUT, ka, 64'hB);
    send(CMD_PUT, 64'h0, 64'hC);
    send(CMD_GET, 64'h1, 64'h0);
    send(CMD_UNKNOWN_LO, kb, 64'hD);
    send(CMD_UNKNOWN_HI, kb, 64'hE);

    // directed: inserts into the smallest table, resize at zero threshold
    drain();
    write_cfg(CFG_LOG_SIZE, CFG_DATA_W'(LOG_SIZE_MIN));
    write_cfg(CFG_THRESHOLD, CFG_DATA_W'(0));
    for (int i = 1; i <= 5; i++) send(CMD_PUT, 64'h100 + VAL_W'(i), VAL_W'(i));
    send(CMD_ADD, 64'h2000, 64'h1);
    send(CMD_ADD, 64'h2000, 64'h2);

    run_phase(10, 768, 0, 300, 40);
    run_phase(3, 0, 74, 250, 12);
    run_phase(4, 5, 26, 250, 20);
    run_phase(0, 2047, 0, 250, 12);
    run_phase(15, 1024, 74, 250, 60);
    run_phase(6, 20, 26, 300, 80);
    run_phase(5, 1, 0, 200, 40);
    run_phase(10, 768, 26, 200, 100);

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d responses over table sizes 8 to 1024 and thresholds 0 to 2047",
             sb.checked);
    $display("saw %0d hits, %0d full tables, %0d resize flags", sb.hits, sb.fulls,
             sb.resizes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
